[rtl/core/pfc_pkg.sv]
// package: widths, microcode word layout and microcode rom for the prime factor counter
package pfc_pkg;

   localparam int VALUE_BITS  = 16;
   localparam int COUNT_BITS  = 5;
   localparam int DIV_BITS    = VALUE_BITS / 2 + 1;
   localparam int DSQ_BITS    = VALUE_BITS + 1;
   localparam int ITER_BITS   = $clog2(VALUE_BITS + 1);
   localparam int STEP_BITS   = 4;

   localparam logic [COUNT_BITS-1:0] TARGET_RESET = COUNT_BITS'(5);

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV_START,
      OP_DIVIDE,
      OP_INC_D,
      OP_TAIL,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_LOOP_DONE,
      COND_DIV_BUSY,
      COND_REM_NZ,
      COND_OUT_BUSY
   } cond_type;

   typedef logic [STEP_BITS-1:0] step_type;

   localparam step_type STEP_IDLE   = step_type'(0);
   localparam step_type STEP_TEST   = step_type'(1);
   localparam step_type STEP_START  = step_type'(2);
   localparam step_type STEP_WAIT   = step_type'(3);
   localparam step_type STEP_CHECK  = step_type'(4);
   localparam step_type STEP_DIVOUT = step_type'(5);
   localparam step_type STEP_NEXT_D = step_type'(6);
   localparam step_type STEP_TAIL   = step_type'(7);
   localparam step_type STEP_HOLD   = step_type'(8);
   localparam step_type STEP_EMIT   = step_type'(9);

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic busy;
      logic rem_zero;
   } div_status_type;

   function automatic ctrl_word_type pfc_rom(input step_type step);
      ctrl_word_type w;
      case (step)
         STEP_IDLE:   w = '{OP_LOAD,      COND_NO_REQ,    STEP_IDLE};
         STEP_TEST:   w = '{OP_NONE,      COND_LOOP_DONE, STEP_TAIL};
         STEP_START:  w = '{OP_DIV_START, COND_NEVER,     STEP_IDLE};
         STEP_WAIT:   w = '{OP_NONE,      COND_DIV_BUSY,  STEP_WAIT};
         STEP_CHECK:  w = '{OP_NONE,      COND_REM_NZ,    STEP_NEXT_D};
         STEP_DIVOUT: w = '{OP_DIVIDE,    COND_ALWAYS,    STEP_START};
         STEP_NEXT_D: w = '{OP_INC_D,     COND_ALWAYS,    STEP_TEST};
         STEP_TAIL:   w = '{OP_TAIL,      COND_NEVER,     STEP_IDLE};
         STEP_HOLD:   w = '{OP_NONE,      COND_OUT_BUSY,  STEP_HOLD};
         STEP_EMIT:   w = '{OP_EMIT,      COND_ALWAYS,    STEP_IDLE};
         default:     w = '{OP_NONE,      COND_ALWAYS,    STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

[rtl/core/prime_factor_count.sv]
// top level: microcoded trial-division prime factor counter with target match
//
//   port group  direction  handshake             word
//   req_        in         req_valid/req_stall   value
//   rsp_        out        rsp_valid/rsp_stall   factor_count, is_match
//   csr_        in         csr_write_en          target_count
//
// each word runs one pass of the shared divider per trial divisor and one more per
// factor divided out.
// synchronous active-high reset clears the step counter, the divider and
// rsp_valid and sets target_count to 5.
// req_stall is high whenever the sequencer is away from its idle step; a result
// waits in the rsp register while the next word is already being worked on.
module prime_factor_count
   import pfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COUNT_BITS-1:0] rsp_factor_count,
   output logic                  rsp_is_match,
   input  logic                  csr_write_en,
   input  logic [COUNT_BITS-1:0] csr_write_data
);

   step_type              step_ff, step_in;
   logic [VALUE_BITS-1:0] q_ff, q_in;
   logic [DIV_BITS-1:0]   d_ff, d_in;
   logic [DSQ_BITS-1:0]   dsq_ff, dsq_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0] target_ff, target_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                  rsp_match_ff, rsp_match_in;

   ctrl_word_type         cw;
   logic                  cond_true;
   logic                  out_busy;
   logic                  div_start;
   logic [VALUE_BITS-1:0] div_quot;
   div_status_type        div_stat;

   pfc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (q_ff),
      .divisor  (d_ff),
      .quotient (div_quot),
      .status   (div_stat)
   );

   assign out_busy = rsp_valid_ff && rsp_stall;

   // sequencer
   always_comb begin
      cw = pfc_rom(step_ff);
      case (cw.cond)
         COND_NEVER:     cond_true = 1'b0;
         COND_ALWAYS:    cond_true = 1'b1;
         COND_NO_REQ:    cond_true = !req_valid;
         COND_LOOP_DONE: cond_true = (q_ff <= VALUE_BITS'(1)) ||
                                     (dsq_ff > DSQ_BITS'(q_ff));
         COND_DIV_BUSY:  cond_true = div_stat.busy;
         COND_REM_NZ:    cond_true = !div_stat.rem_zero;
         COND_OUT_BUSY:  cond_true = out_busy;
         default:        cond_true = 1'b1;
      endcase
      step_in = cond_true ? cw.target : step_ff + step_type'(1);
   end

   // datapath
   always_comb begin
      q_in         = q_ff;
      d_in         = d_ff;
      dsq_in       = dsq_ff;
      cnt_in       = cnt_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;
      rsp_match_in = rsp_match_ff;
      target_in    = csr_write_en ? csr_write_data : target_ff;
      case (cw.op)
         OP_LOAD: begin
            if (req_valid) begin
               q_in   = req_value;
               d_in   = DIV_BITS'(2);
               dsq_in = DSQ_BITS'(4);
               cnt_in = '0;
            end
         end
         OP_DIV_START: div_start = 1'b1;
         OP_DIVIDE: begin
            q_in   = div_quot;
            cnt_in = cnt_ff + COUNT_BITS'(1);
         end
         OP_INC_D: begin
            d_in   = d_ff + DIV_BITS'(1);
            dsq_in = dsq_ff + DSQ_BITS'({d_ff, 1'b0}) + DSQ_BITS'(1);
         end
         OP_TAIL: begin
            if (q_ff > VALUE_BITS'(1)) begin
               cnt_in = cnt_ff + COUNT_BITS'(1);
            end
         end
         OP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_count_in = cnt_ff;
            rsp_match_in = (cnt_ff == target_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         target_ff    <= TARGET_RESET;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         target_ff    <= target_in;
      end
      q_ff         <= q_in;
      d_ff         <= d_in;
      dsq_ff       <= dsq_in;
      cnt_ff       <= cnt_in;
      rsp_count_ff <= rsp_count_in;
      rsp_match_ff <= rsp_match_in;
   end

   assign req_stall        = (step_ff != STEP_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_factor_count = rsp_count_ff;
   assign rsp_is_match     = rsp_match_ff;

endmodule

[rtl/core/pfc_div.sv]
// restoring divider, one quotient bit per cycle
module pfc_div
   import pfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [DIV_BITS-1:0]   divisor,
   output logic [VALUE_BITS-1:0] quotient,
   output div_status_type        status
);

   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [DIV_BITS-1:0]   rem_ff, rem_in;
   logic [ITER_BITS-1:0]  iter_ff, iter_in;
   logic [DIV_BITS:0]     trial;

   always_comb begin
      trial   = {rem_ff, quot_ff[VALUE_BITS-1]} - {1'b0, divisor};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      iter_in = iter_ff;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         iter_in = ITER_BITS'(VALUE_BITS);
      end else if (iter_ff != '0) begin
         iter_in = iter_ff - ITER_BITS'(1);
         if (!trial[DIV_BITS]) begin
            rem_in  = trial[DIV_BITS-1:0];
            quot_in = {quot_ff[VALUE_BITS-2:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[DIV_BITS-2:0], quot_ff[VALUE_BITS-1]};
            quot_in = {quot_ff[VALUE_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
      end else begin
         iter_ff <= iter_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign quotient        = quot_ff;
   assign status.busy     = (iter_ff != '0);
   assign status.rem_zero = (rem_ff == '0);

endmodule

[tb/sv/prime_factor_count_tb.sv]
// testbench for prime_factor_count: directed table and random values against a predictor
module prime_factor_count_tb
   import pfc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD   = 2;
   localparam int RESET_CYCLES  = 5;
   localparam int LIMIT_CYCLES  = 4_000_000;
   localparam int HOLD_CYCLES   = 6000;
   localparam int SETTLE_CYCLES = 6000;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_ITEMS   = 17;
   localparam int N_DIRECTED    = 23;

   typedef struct packed {
      logic [COUNT_BITS-1:0] factor_count;
      logic                  is_match;
   } factor_word_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [COUNT_BITS-1:0] target;
      logic                  typed;
      logic [COUNT_BITS-1:0] count;
      logic                  match;
   } directed_row_type;

   // value, target, typed-in expectation or predictor
   directed_row_type directed_rows [N_DIRECTED] = '{
      '{16'd0,     5'd5,  1'b1, 5'd0,  1'b0},
      '{16'd1,     5'd5,  1'b1, 5'd0,  1'b0},
      '{16'd2,     5'd5,  1'b1, 5'd1,  1'b0},
      '{16'd4,     5'd5,  1'b1, 5'd2,  1'b0},
      '{16'd32,    5'd5,  1'b1, 5'd5,  1'b1},
      '{16'd65535, 5'd5,  1'b0, 5'd0,  1'b0},
      '{16'd65521, 5'd5,  1'b0, 5'd0,  1'b0},
      '{16'd63001, 5'd5,  1'b0, 5'd0,  1'b0},
      '{16'd30030, 5'd5,  1'b0, 5'd0,  1'b0},
      '{16'd243,   5'd5,  1'b1, 5'd5,  1'b1},
      '{16'd0,     5'd0,  1'b1, 5'd0,  1'b1},
      '{16'd1,     5'd0,  1'b1, 5'd0,  1'b1},
      '{16'd7,     5'd0,  1'b1, 5'd1,  1'b0},
      '{16'd32768, 5'd15, 1'b1, 5'd15, 1'b1},
      '{16'd49152, 5'd15, 1'b0, 5'd0,  1'b0},
      '{16'd65534, 5'd15, 1'b0, 5'd0,  1'b0},
      '{16'd32768, 5'd16, 1'b1, 5'd15, 1'b0},
      '{16'd65025, 5'd16, 1'b0, 5'd0,  1'b0},
      '{16'd0,     5'd31, 1'b1, 5'd0,  1'b0},
      '{16'd32768, 5'd31, 1'b1, 5'd15, 1'b0},
      '{16'd65521, 5'd1,  1'b0, 5'd0,  1'b0},
      '{16'd21845, 5'd1,  1'b0, 5'd0,  1'b0},
      '{16'd4,     5'd2,  1'b1, 5'd2,  1'b1}
   };

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_value      = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [COUNT_BITS-1:0] rsp_factor_count;
   logic                  rsp_is_match;
   logic                  csr_write_en   = 1'b0;
   logic [COUNT_BITS-1:0] csr_write_data = '0;

   factor_word_type       expected_counts [$];
   logic [COUNT_BITS-1:0] target_now = TARGET_RESET;
   int                    error_count = 0;
   int                    values_sent = 0;
   int                    results_checked = 0;
   int                    matches_seen = 0;
   int                    target_writes = 0;
   int                    burst_left = 0;
   int                    gap_max = 0;
   logic                  hold_req = 1'b0;
   logic                  hold_done = 1'b0;
   int                    hold_left = 0;
   logic [15:0]           rx_cycle = '0;

   prime_factor_count DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_factor_count (rsp_factor_count),
      .rsp_is_match     (rsp_is_match),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic logic [COUNT_BITS-1:0] big_omega(input logic [VALUE_BITS-1:0] v);
      int unsigned q;
      int unsigned d;
      int unsigned n;
      q = v;
      d = 2;
      n = 0;
      while (q > 1 && d * d <= q) begin
         while (q % d == 0) begin
            n++;
            q = q / d;
         end
         d++;
      end
      if (q > 1)
         n++;
      return n[COUNT_BITS-1:0];
   endfunction

   function automatic logic [VALUE_BITS-1:0] random_value();
      int unsigned p;
      int unsigned f;
      int unsigned small_primes [6];
      small_primes = '{2, 3, 5, 7, 11, 13};
      p = 1;
      case ($urandom_range(0, 9))
         0, 1, 2: return VALUE_BITS'($urandom_range(0, 65535));
         3, 4:    return VALUE_BITS'($urandom_range(0, 255));
         5, 6:    return VALUE_BITS'($urandom_range(0, 4095));
         default: begin
            repeat ($urandom_range(1, 16)) begin
               f = small_primes[$urandom_range(0, 5)];
               if (p * f <= 65535)
                  p = p * f;
            end
            return VALUE_BITS'(p);
         end
      endcase
   endfunction

   task automatic offer(input logic [VALUE_BITS-1:0] v, input logic typed,
                        input factor_word_type typed_word);
      int              gap;
      factor_word_type want;
      if (burst_left == 0) begin
         if (gap_max > 0) begin
            gap = $urandom_range(1, gap_max);
            req_valid <= 1'b0;
            req_value <= VALUE_BITS'($urandom);
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      if (typed) begin
         want = typed_word;
      end else begin
         want.factor_count = big_omega(v);
         want.is_match     = (want.factor_count == target_now);
      end
      expected_counts.push_back(want);
      values_sent++;
   endtask

   task automatic set_target(input logic [COUNT_BITS-1:0] t);
      req_valid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= t;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      target_now = t;
      target_writes++;
   endtask

   always @(posedge clock) begin : rsp_side
      factor_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_counts.size() == 0) begin
               $error("unexpected word: factor_count %0d is_match %0d",
                      rsp_factor_count, rsp_is_match);
               error_count++;
            end else begin
               want = expected_counts.pop_front();
               results_checked++;
               if (rsp_is_match === 1'b1)
                  matches_seen++;
               if (rsp_factor_count !== want.factor_count) begin
                  $error("factor_count: expected %0d, got %0d",
                         want.factor_count, rsp_factor_count);
                  error_count++;
               end
               if (rsp_is_match !== want.is_match) begin
                  $error("is_match: expected %0d, got %0d", want.is_match, rsp_is_match);
                  error_count++;
               end
            end
         end
         rx_cycle++;
         // one long hold-off so the block backs up into its input
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
         end else begin
            case (rx_cycle[8:7])
               2'd0:    rsp_stall <= 1'b0;
               2'd1:    rsp_stall <= ($urandom_range(0, 3) == 0);
               2'd2:    rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= rx_cycle[0];
            endcase
         end
      end
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("prime_factor_count_tb: errors");
      $finish;
   end

   initial begin
      factor_word_type typed_word;
      int              i;
      int              ph;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      gap_max = 3;
      for (i = 0; i < N_DIRECTED; i++) begin
         if (directed_rows[i].target != target_now)
            set_target(directed_rows[i].target);
         typed_word.factor_count = directed_rows[i].count;
         typed_word.is_match     = directed_rows[i].match;
         offer(directed_rows[i].value, directed_rows[i].typed, typed_word);
      end

      typed_word = '0;
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph % 3 == 2)
            set_target(COUNT_BITS'($urandom_range(0, 31)));
         else
            set_target(COUNT_BITS'($urandom_range(1, 6)));
         gap_max    = (ph % 3 == 0) ? 20 : ((ph % 3 == 1) ? 0 : 4);
         burst_left = 0;
         if (ph == 1)
            hold_req = 1'b1;
         for (i = 0; i < PHASE_ITEMS; i++)
            offer(random_value(), 1'b0, typed_word);
      end

      req_valid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("prime_factor_count_tb: %0d values sent, %0d result words checked",
               values_sent, results_checked);
      $display("prime_factor_count_tb: %0d target writes, %0d words flagged as matching",
               target_writes, matches_seen);
      if (error_count == 0)
         $display("prime_factor_count_tb: clean");
      else
         $display("prime_factor_count_tb: errors");
      $finish;
   end

endmodule
